// ===== rtl/core/dvi_pkg.sv =====
package dvi_pkg;

  localparam int DVI_ID_CHANNELS = 3;
  localparam int DVI_VALUE_W = 64;
  localparam int DVI_BYTE_W = 8;

  localparam logic [1:0] MODE_UNSIGNED = 2'd0;
  localparam logic [1:0] MODE_SIGNED = 2'd1;
  localparam logic [1:0] MODE_DELTA = 2'd2;
  localparam logic [1:0] MODE_RESET = 2'd3;

  localparam logic [1:0] KIND_UNS = 2'd0;
  localparam logic [1:0] KIND_SGN = 2'd1;
  localparam logic [1:0] KIND_RST = 2'd2;

  localparam logic [DVI_BYTE_W-1:0] RESET_MARK = 8'hff;

  typedef struct packed {
    logic valid;
    logic [1:0] kind;
    logic [DVI_VALUE_W-1:0] bits;
  } dvi_load_t;

endpackage

// ===== rtl/core/dvi_emit.sv =====
module dvi_emit
  import dvi_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  dvi_load_t load,
  output logic busy,
  output logic out_valid,
  input  logic out_ready,
  output logic [DVI_BYTE_W-1:0] out_byte,
  output logic out_last
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic state;
  logic [1:0] kind;
  logic first;
  logic [DVI_VALUE_W-1:0] sh;
  logic [DVI_VALUE_W-1:0] sh_next;
  logic [DVI_VALUE_W-1:0] mag;
  logic [DVI_BYTE_W-1:0] byte_next;
  logic more;
  logic advance;

  assign busy = (state == ST_EMIT);
  assign advance = busy && (!out_valid || out_ready);

  always_comb begin
    mag = (first && kind == KIND_SGN && sh[DVI_VALUE_W-1]) ? ~sh : sh;
    if (kind == KIND_RST) begin
      more = 1'b0;
      byte_next = RESET_MARK;
      sh_next = sh;
    end else if (first && kind == KIND_SGN) begin
      more = (mag[DVI_VALUE_W-1:6] != '0);
      byte_next = {more, mag[5:0], sh[DVI_VALUE_W-1]};
      sh_next = mag >> 6;
    end else begin
      more = (sh[DVI_VALUE_W-1:7] != '0);
      byte_next = {more, sh[6:0]};
      sh_next = sh >> 7;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
      first <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (load.valid) begin
            state <= ST_EMIT;
            first <= 1'b1;
          end
        end
        ST_EMIT: begin
          if (advance) begin
            first <= 1'b0;
            if (!more) begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && load.valid) begin
      kind <= load.kind;
      sh <= load.bits;
    end else if (advance) begin
      sh <= sh_next;
    end
    if (advance) begin
      out_byte <= byte_next;
      out_last <= !more;
    end
  end

endmodule

// ===== rtl/core/delta_varint_id_encoder_top.sv =====
// channel  dir  tdata               tuser                   tlast
// s_axis   in   value[63:0]         mode[1:0] channel[3:2]  -
// m_axis   out  out_byte[7:0]       -                       last_byte
//
// an item is loaded, then emitted as output bytes:
// 1 byte for reset, up to 5 unsigned, up to 10 signed or delta
// the emitter shifts out one 7-bit digit (first signed: 6) per unstalled cycle
// s_axis_tready rises once the final byte of an item sits in the output register
// a stalled m_axis holds the emitter; rst clears all channel ids
module delta_varint_id_encoder_top
  import dvi_pkg::*;
#(
  parameter int ID_CHANNELS = DVI_ID_CHANNELS
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // value[63:0]
  input  logic [3:0] s_axis_tuser,   // mode[1:0], channel[3:2]
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  output logic [7:0] m_axis_tdata,   // out_byte[7:0]
  output logic m_axis_tlast
);

  localparam int CH_W = (ID_CHANNELS > 1) ? $clog2(ID_CHANNELS) : 1;

  logic [DVI_VALUE_W-1:0] previous_id [ID_CHANNELS];
  logic [1:0] mode;
  logic [1:0] channel;
  logic [7:0] channel_ext;
  logic [CH_W-1:0] ch_idx;
  logic ch_ok;
  logic accept;
  logic busy;
  dvi_load_t load;

  assign mode = s_axis_tuser[1:0];
  assign channel = s_axis_tuser[3:2];
  assign channel_ext = {6'd0, channel};
  assign ch_idx = channel_ext[CH_W-1:0];
  assign ch_ok = (32'(channel) < 32'(ID_CHANNELS));
  assign s_axis_tready = !busy;
  assign accept = s_axis_tvalid && s_axis_tready;

  always_comb begin
    load.valid = accept;
    load.kind = KIND_SGN;
    load.bits = s_axis_tdata;
    unique case (mode)
      MODE_UNSIGNED: begin
        load.kind = KIND_UNS;
        load.bits = {32'd0, s_axis_tdata[31:0]};
      end
      MODE_SIGNED: begin
        load.kind = KIND_SGN;
      end
      MODE_DELTA: begin
        load.kind = KIND_SGN;
        if (ch_ok) begin
          load.bits = s_axis_tdata - previous_id[ch_idx];
        end
      end
      MODE_RESET: begin
        load.kind = KIND_RST;
      end
      default: load.kind = KIND_SGN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ID_CHANNELS; i++) begin
        previous_id[i] <= '0;
      end
    end else if (accept) begin
      if (mode == MODE_RESET) begin
        for (int i = 0; i < ID_CHANNELS; i++) begin
          previous_id[i] <= '0;
        end
      end else if (mode == MODE_DELTA && ch_ok) begin
        previous_id[ch_idx] <= s_axis_tdata;
      end
    end
  end

  dvi_emit u_emit (
    .clk(clk),
    .rst(rst),
    .load(load),
    .busy(busy),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_byte(m_axis_tdata),
    .out_last(m_axis_tlast)
  );

endmodule

// ===== rtl/core/dvi_checker.sv =====
module dvi_checker (
  input logic clk,
  input logic rst,
  input logic s_axis_tvalid,
  input logic s_axis_tready,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic m_axis_tlast
);

  // a byte without continuation ends the request
  a_stop_is_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[7] |-> m_axis_tlast)
    else $error("byte without continuation not marked last");

  // a final byte has no continuation unless it is the reset marker
  a_last_form: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |-> !m_axis_tdata[7] || m_axis_tdata == 8'hff)
    else $error("final byte carries continuation");

  // a new request is taken only once the pending byte closes the previous one
  a_ready_after_last: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready && m_axis_tvalid |-> m_axis_tlast)
    else $error("input ready while a request is unfinished");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready right after a request");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled output changed");

endmodule

bind delta_varint_id_encoder_top dvi_checker u_dvi_checker (
  .clk(clk),
  .rst(rst),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata),
  .m_axis_tlast(m_axis_tlast)
);

// ===== tb/sv/tb_delta_varint_id_encoder_top.sv =====
module tb_delta_varint_id_encoder_top
  import dvi_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_LIMIT = 100000;
  localparam int TAIL_CYCLES = 32;

  typedef struct packed {
    logic [7:0] data;
    logic last;
  } enc_byte_t;

  logic clk = 1'b0;
  logic rst;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [63:0] s_axis_tdata;
  logic [3:0] s_axis_tuser;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic m_axis_tlast;

  enc_byte_t expected_bytes[$];
  logic [63:0] channel_last_id[DVI_ID_CHANNELS];
  int fail_count = 0;
  bit src_idle_en = 1'b1;
  bit snk_idle_en = 1'b1;
  bit hold_active = 1'b0;
  event hold_trigger;

  delta_varint_id_encoder_top dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic void add_expected(logic [7:0] data, logic last);
    enc_byte_t e;
    e.data = data;
    e.last = last;
    expected_bytes.insert(expected_bytes.size(), e);
  endfunction

  function automatic void encode_unsigned_bytes(logic [31:0] v);
    logic [31:0] rest;
    do begin
      rest = v >> 7;
      add_expected({rest != 0, v[6:0]}, rest == 0);
      v = rest;
    end while (v != 0);
  endfunction

  function automatic void encode_signed_bytes(logic [63:0] b);
    logic neg;
    logic [63:0] mag;
    logic [63:0] rest;
    neg = b[63];
    mag = neg ? ~b : b;
    rest = mag >> 6;
    add_expected({rest != 0, mag[5:0], neg}, rest == 0);
    mag = rest;
    while (mag != 0) begin
      rest = mag >> 7;
      add_expected({rest != 0, mag[6:0]}, rest == 0);
      mag = rest;
    end
  endfunction

  function automatic void predict_encoding(logic [1:0] mode, logic [1:0] channel,
                                           logic [63:0] value);
    logic [63:0] diff;
    case (mode)
      MODE_UNSIGNED: encode_unsigned_bytes(value[31:0]);
      MODE_SIGNED: encode_signed_bytes(value);
      MODE_DELTA: begin
        if (channel < DVI_ID_CHANNELS) begin
          diff = value - channel_last_id[channel];
          channel_last_id[channel] = value;
          encode_signed_bytes(diff);
        end else begin
          encode_signed_bytes(value);
        end
      end
      default: begin
        foreach (channel_last_id[i]) channel_last_id[i] = '0;
        add_expected(RESET_MARK, 1'b1);
      end
    endcase
  endfunction

  function automatic logic [63:0] random_value();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 3))
      0: r = r >> $urandom_range(0, 63);
      1: r = ~(r >> $urandom_range(0, 63));
      2: ;
      default: begin
        case ($urandom_range(0, 3))
          0: r = '0;
          1: r = '1;
          2: r = 64'h8000_0000_0000_0000;
          default: r = 64'h7fff_ffff_ffff_ffff;
        endcase
      end
    endcase
    return r;
  endfunction

  task automatic send_request(logic [1:0] mode, logic [1:0] channel, logic [63:0] value);
    if (src_idle_en && $urandom_range(0, 99) < 25) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= value;
    s_axis_tuser <= {channel, mode};
    do @(posedge clk); while (!s_axis_tready);
    predict_encoding(mode, channel, value);
  endtask

  // receive side: random stalls, long hold on request
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_bytes.size() == 0) begin
        $error("unexpected byte %h last %b", m_axis_tdata, m_axis_tlast);
        fail_count++;
      end else begin
        if (m_axis_tdata !== expected_bytes[0].data) begin
          $error("out_byte expected %h actual %h", expected_bytes[0].data, m_axis_tdata);
          fail_count++;
        end
        if (m_axis_tlast !== expected_bytes[0].last) begin
          $error("last_byte expected %b actual %b", expected_bytes[0].last, m_axis_tlast);
          fail_count++;
        end
        void'(expected_bytes.pop_front());
      end
    end
    if (hold_active) begin
      m_axis_tready <= 1'b0;
    end else if (snk_idle_en) begin
      m_axis_tready <= $urandom_range(0, 99) >= 25;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  initial begin
    forever begin
      @(hold_trigger);
      @(posedge clk);
      hold_active <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_active <= 1'b0;
    end
  end

  task automatic test_unsigned_extremes();
    send_request(MODE_UNSIGNED, 2'd0, 64'd0);
    send_request(MODE_UNSIGNED, 2'd1, 64'd127);
    send_request(MODE_UNSIGNED, 2'd2, 64'd128);
    send_request(MODE_UNSIGNED, 2'd3, 64'd16384);
    send_request(MODE_UNSIGNED, 2'd0, 64'h0000_0000_ffff_ffff);
    send_request(MODE_UNSIGNED, 2'd0, 64'hdead_beef_0000_0005);
  endtask

  task automatic test_signed_extremes();
    send_request(MODE_SIGNED, 2'd0, 64'd0);
    send_request(MODE_SIGNED, 2'd3, '1);
    send_request(MODE_SIGNED, 2'd1, 64'd63);
    send_request(MODE_SIGNED, 2'd2, 64'd64);
    send_request(MODE_SIGNED, 2'd0, -64'sd64);
    send_request(MODE_SIGNED, 2'd0, -64'sd65);
    send_request(MODE_SIGNED, 2'd0, 64'h7fff_ffff_ffff_ffff);
    send_request(MODE_SIGNED, 2'd0, 64'h8000_0000_0000_0000);
  endtask

  task automatic test_delta_channels();
    send_request(MODE_DELTA, 2'd0, 64'd1000);
    send_request(MODE_DELTA, 2'd0, 64'd999);
    send_request(MODE_DELTA, 2'd1, -64'sd5);
    send_request(MODE_DELTA, 2'd2, 64'h8000_0000_0000_0000);
    send_request(MODE_DELTA, 2'd2, 64'h7fff_ffff_ffff_ffff);
    // out of range channel: plain signed, no id update
    send_request(MODE_DELTA, 2'd3, 64'd42);
    send_request(MODE_DELTA, 2'd1, 64'd100);
  endtask

  task automatic test_reset_mode();
    send_request(MODE_RESET, 2'd3, {$urandom, $urandom});
    send_request(MODE_DELTA, 2'd0, 64'd10);
    send_request(MODE_DELTA, 2'd2, 64'd10);
    send_request(MODE_RESET, 2'd0, '0);
  endtask

  task automatic send_random_request();
    logic [1:0] mode;
    logic [1:0] channel;
    logic [63:0] value;
    logic signed [31:0] step;
    if ($urandom_range(0, 99) < 5) mode = MODE_RESET;
    else mode = 2'($urandom_range(0, 2));
    if ($urandom_range(0, 9) == 0) channel = 2'd3;
    else channel = 2'($urandom_range(0, 2));
    if (mode == MODE_DELTA && channel < DVI_ID_CHANNELS && $urandom_range(0, 2) != 0) begin
      step = $urandom;
      step = step >>> $urandom_range(0, 31);
      value = channel_last_id[channel] + {{32{step[31]}}, step};
    end else begin
      value = random_value();
    end
    send_request(mode, channel, value);
  endtask

  task automatic test_random_traffic(int count);
    repeat (count) send_random_request();
  endtask

  task automatic test_no_idle_burst(int count);
    src_idle_en = 1'b0;
    snk_idle_en <= 1'b0;
    repeat (count) send_random_request();
    src_idle_en = 1'b1;
    snk_idle_en <= 1'b1;
  endtask

  task automatic test_output_backpressure(int count);
    src_idle_en = 1'b0;
    -> hold_trigger;
    repeat (count) send_random_request();
    src_idle_en = 1'b1;
  endtask

  initial begin
    int waited;
    rst <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= '0;
    foreach (channel_last_id[i]) channel_last_id[i] = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_unsigned_extremes();
    test_signed_extremes();
    test_delta_channels();
    test_reset_mode();
    test_random_traffic(150);
    test_no_idle_burst(60);
    test_output_backpressure(40);
    test_random_traffic(150);

    s_axis_tvalid <= 1'b0;
    waited = 0;
    while (expected_bytes.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (expected_bytes.size() != 0) begin
      $error("%0d expected bytes never arrived", expected_bytes.size());
      fail_count++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
